// ===== src/bidu_pkg.sv =====
// Shared types and constants for the banked interrupt dispatcher.
package bidu_pkg;

  localparam int BANK_W  = 32;
  localparam int NBANKS  = 3;
  localparam int IDX_W   = 5;
  localparam int BSEL_W  = 2;
  localparam int SRC_W   = 7;
  localparam int MODE_W  = 3;
  localparam int STAT_W  = 10;

  localparam logic [MODE_W-1:0] MODE_ENABLE   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DISABLE  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ATTACH   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DETACH   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DISPATCH = 3'd4;

  localparam logic [BSEL_W-1:0] BANK_0 = 2'd0;
  localparam logic [BSEL_W-1:0] BANK_1 = 2'd1;
  localparam logic [BSEL_W-1:0] BANK_2 = 2'd2;

  localparam int BANK0_GATE_BIT = 8;
  localparam int BANK1_GATE_BIT = 9;
  localparam int BANK2_PEND_W   = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN
  } state_t;

  // Single-bit update to the enable or handler-attached banks.
  typedef struct packed {
    logic              we;
    logic [MODE_W-1:0] op;
    logic [BSEL_W-1:0] bank;
    logic [IDX_W-1:0]  bit_idx;
  } wr_cmd_t;

  // What the scanner reports for the bit position it is looking at.
  typedef struct packed {
    logic             fire;
    logic             last;
    logic [IDX_W-1:0] bit_idx;
  } scan_out_t;

endpackage

// ===== src/bidu_bank_store.sv =====
// Enable and handler-attached bit banks with one update port and one bank read port.
module bidu_bank_store
  import bidu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  wr_cmd_t           wr,
  input  logic [BSEL_W-1:0] rd_bank,
  output logic [BANK_W-1:0] rd_enable,
  output logic [BANK_W-1:0] rd_attached
);

  logic [BANK_W-1:0] enable_r   [NBANKS];
  logic [BANK_W-1:0] attached_r [NBANKS];
  logic [BANK_W-1:0] enable_nxt [NBANKS];
  logic [BANK_W-1:0] attached_nxt [NBANKS];
  logic [BANK_W-1:0] bit_mask;

  assign bit_mask = BANK_W'(1) << wr.bit_idx;

  always_comb begin
    for (int b = 0; b < NBANKS; b++) begin
      enable_nxt[b]   = enable_r[b];
      attached_nxt[b] = attached_r[b];
      if (wr.we && (wr.bank == BSEL_W'(b))) begin
        case (wr.op)
          MODE_ENABLE:  enable_nxt[b]   = enable_r[b] | bit_mask;
          MODE_DISABLE: enable_nxt[b]   = enable_r[b] & ~bit_mask;
          MODE_ATTACH:  attached_nxt[b] = attached_r[b] | bit_mask;
          MODE_DETACH:  attached_nxt[b] = attached_r[b] & ~bit_mask;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int b = 0; b < NBANKS; b++) begin
      if (!rst_n) begin
        enable_r[b]   <= '0;
        attached_r[b] <= '0;
      end else begin
        enable_r[b]   <= enable_nxt[b];
        attached_r[b] <= attached_nxt[b];
      end
    end
  end

  always_comb begin
    case (rd_bank)
      BANK_0: begin
        rd_enable   = enable_r[0];
        rd_attached = attached_r[0];
      end
      BANK_1: begin
        rd_enable   = enable_r[1];
        rd_attached = attached_r[1];
      end
      BANK_2: begin
        rd_enable   = enable_r[2];
        rd_attached = attached_r[2];
      end
      default: begin
        rd_enable   = '0;
        rd_attached = '0;
      end
    endcase
  end

endmodule

// ===== src/bidu_scan_unit.sv =====
// Shift-based bit scanner that walks a word from its top bit down, one position a cycle.
module bidu_scan_unit
  import bidu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic [BANK_W-1:0] word,
  output scan_out_t         scan
);

  logic [BANK_W-1:0] word_r, word_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              active_r, active_nxt;

  always_comb begin
    scan.fire    = active_r && word_r[BANK_W-1];
    scan.last    = (word_r[BANK_W-2:0] == '0);
    scan.bit_idx = idx_r;
  end

  always_comb begin
    word_nxt   = word_r;
    idx_nxt    = idx_r;
    active_nxt = active_r;
    if (load) begin
      word_nxt   = word;
      idx_nxt    = IDX_W'(BANK_W - 1);
      active_nxt = 1'b1;
    end else if (active_r) begin
      word_nxt = word_r << 1;
      idx_nxt  = idx_r - IDX_W'(1);
      // The scan stops once the final set bit has been reported.
      if (scan.fire && scan.last) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    idx_r  <= idx_nxt;
  end

endmodule

// ===== src/banked_interrupt_dispatcher_unit.sv =====
// Top level of the banked interrupt dispatcher: sequencer, bank store and bit scanner.
// Enable, disable, attach and detach items pass through the execute state and give
// their single result from a register loaded in that state.
// A dispatch item with something to report loads the shift scanner, which visits one bit
// position per cycle from bit 31 down to the lowest set bit, the bank width setting the
// worst case. A dispatch with nothing to report, and an unused mode, give one empty result.
// Reset (rst_n low, synchronous) clears every enable and handler-attached bit.
// Results appear for a single cycle on out_valid; the receiver cannot stall them.
module banked_interrupt_dispatcher_unit
  import bidu_pkg::*;
#(
  parameter int NUM_SOURCES = 72
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [SRC_W-1:0]  in_source_number,
  input  logic [BSEL_W-1:0] in_bank_select,
  input  logic [STAT_W-1:0] in_basic_status,
  input  logic [BANK_W-1:0] in_pending_word,
  output logic              out_valid,
  output logic [SRC_W-1:0]  out_source_out,
  output logic              out_fired,
  output logic              out_range_error,
  output logic              out_last
);

  // Sources at or above this limit are rejected by the bit commands.
  localparam logic [SRC_W:0] SRC_LIMIT = (SRC_W + 1)'(NUM_SOURCES);

  state_t state_r, state_nxt;

  // Captured item.
  logic [MODE_W-1:0] mode_r;
  logic [SRC_W-1:0]  src_r;
  logic [BSEL_W-1:0] bank_r;
  logic [STAT_W-1:0] status_r;
  logic [BANK_W-1:0] pend_r;

  // Registered result.
  logic              out_valid_r, out_valid_nxt;
  logic [SRC_W-1:0]  out_src_r, out_src_nxt;
  logic              out_fired_r, out_fired_nxt;
  logic              out_rerr_r, out_rerr_nxt;
  logic              out_last_r, out_last_nxt;

  wr_cmd_t           wr;
  logic [BANK_W-1:0] rd_enable;
  logic [BANK_W-1:0] rd_attached;
  logic [BANK_W-1:0] pend_sel;
  logic [BANK_W-1:0] masked;
  logic              gate;
  logic              range_err;
  logic              is_cmd;
  logic              is_dispatch;
  logic              scan_load;
  scan_out_t         scan;
  logic              accept;

  assign accept      = start && !busy;
  assign busy        = (state_r != ST_IDLE);
  assign is_cmd      = (mode_r == MODE_ENABLE) || (mode_r == MODE_DISABLE) ||
                       (mode_r == MODE_ATTACH) || (mode_r == MODE_DETACH);
  assign is_dispatch = (mode_r == MODE_DISPATCH);
  assign range_err   = ({1'b0, src_r} >= SRC_LIMIT);

  // Each bank has its own gate in the basic status word; bank 2 takes its raw
  // pending bits from the low byte of that word as well.
  always_comb begin
    case (bank_r)
      BANK_0: begin
        gate     = status_r[BANK0_GATE_BIT];
        pend_sel = pend_r;
      end
      BANK_1: begin
        gate     = status_r[BANK1_GATE_BIT];
        pend_sel = pend_r;
      end
      BANK_2: begin
        gate     = |status_r[BANK2_PEND_W-1:0];
        pend_sel = BANK_W'(status_r[BANK2_PEND_W-1:0]);
      end
      default: begin
        gate     = 1'b0;
        pend_sel = '0;
      end
    endcase
  end

  assign masked = gate ? (pend_sel & rd_enable & rd_attached) : '0;

  bidu_bank_store u_store (
    .clk         (clk),
    .rst_n       (rst_n),
    .wr          (wr),
    .rd_bank     (bank_r),
    .rd_enable   (rd_enable),
    .rd_attached (rd_attached)
  );

  bidu_scan_unit u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .load  (scan_load),
    .word  (masked),
    .scan  (scan)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (is_dispatch && (masked != '0)) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (scan.fire && scan.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output and control logic. A command produces an acknowledgement; a dispatch
  // with nothing to report, or an unused mode, produces one empty item; otherwise
  // the scanner runs and every set bit it meets becomes a fired item.
  always_comb begin
    wr            = '0;
    wr.op         = mode_r;
    wr.bank       = src_r[SRC_W-1:IDX_W];
    wr.bit_idx    = src_r[IDX_W-1:0];
    scan_load     = 1'b0;
    out_valid_nxt = 1'b0;
    out_src_nxt   = '0;
    out_fired_nxt = 1'b0;
    out_rerr_nxt  = 1'b0;
    out_last_nxt  = 1'b1;
    case (state_r)
      ST_EXEC: begin
        if (is_cmd) begin
          wr.we         = !range_err;
          out_valid_nxt = 1'b1;
          out_rerr_nxt  = range_err;
        end else if (is_dispatch && (masked != '0)) begin
          scan_load = 1'b1;
        end else begin
          out_valid_nxt = 1'b1;
        end
      end
      ST_SCAN: begin
        if (scan.fire) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = {bank_r, scan.bit_idx};
          out_fired_nxt = 1'b1;
          out_last_nxt  = scan.last;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_src_r   <= out_src_nxt;
    out_fired_r <= out_fired_nxt;
    out_rerr_r  <= out_rerr_nxt;
    out_last_r  <= out_last_nxt;
    if (accept) begin
      mode_r   <= in_mode;
      src_r    <= in_source_number;
      bank_r   <= in_bank_select;
      status_r <= in_basic_status;
      pend_r   <= in_pending_word;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_source_out  = out_src_r;
  assign out_fired       = out_fired_r;
  assign out_range_error = out_rerr_r;
  assign out_last        = out_last_r;

endmodule

// ===== dv/dispatch_checker.sv =====
// Result checker for the banked interrupt dispatcher: mirrors the banks and compares every result.
`timescale 1ns / 1ps

module dispatch_checker
  import bidu_pkg::*;
#(
  parameter int NUM_SOURCES = 72
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [SRC_W-1:0]  in_source_number,
  input  logic [BSEL_W-1:0] in_bank_select,
  input  logic [STAT_W-1:0] in_basic_status,
  input  logic [BANK_W-1:0] in_pending_word,
  input  logic              out_valid,
  input  logic [SRC_W-1:0]  out_source_out,
  input  logic              out_fired,
  input  logic              out_range_error,
  input  logic              out_last,
  output int unsigned       mismatch_count,
  output int unsigned       result_count,
  output int unsigned       awaited_count
);

  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic             fired;
    logic             range_error;
    logic             last;
  } irq_result_t;

  logic [BANK_W-1:0] enable_mirror  [NBANKS];
  logic [BANK_W-1:0] handler_mirror [NBANKS];
  irq_result_t       due_results    [$];

  function automatic irq_result_t make_result(input logic [SRC_W-1:0] source,
                                              input logic fired, input logic range_error,
                                              input logic last);
    irq_result_t r;
    r.source      = source;
    r.fired       = fired;
    r.range_error = range_error;
    r.last        = last;
    return r;
  endfunction

  // Works out every result an accepted item causes and updates the mirrored banks.
  task automatic predict_item(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] src,
                              input logic [BSEL_W-1:0] bank, input logic [STAT_W-1:0] status,
                              input logic [BANK_W-1:0] pend);
    logic [BANK_W-1:0] masked;
    logic [BANK_W-1:0] bit_mask;
    int                base;
    int                sel;
    int                emitted;
    masked  = '0;
    base    = 0;
    sel     = 0;
    emitted = 0;
    if (mode <= MODE_DETACH) begin
      if (src >= NUM_SOURCES) begin
        due_results.push_back(make_result('0, 1'b0, 1'b1, 1'b1));
      end else begin
        sel      = (src[6:5] > 2'd2) ? 2 : int'(src[6:5]);
        bit_mask = BANK_W'(1) << src[IDX_W-1:0];
        case (mode)
          MODE_ENABLE:  enable_mirror[sel]  = enable_mirror[sel] | bit_mask;
          MODE_DISABLE: enable_mirror[sel]  = enable_mirror[sel] & ~bit_mask;
          MODE_ATTACH:  handler_mirror[sel] = handler_mirror[sel] | bit_mask;
          default:      handler_mirror[sel] = handler_mirror[sel] & ~bit_mask;
        endcase
        due_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
      end
    end else if (mode == MODE_DISPATCH) begin
      if (bank == BANK_0 && status[BANK0_GATE_BIT]) begin
        masked = pend & enable_mirror[0];
        base   = 0;
        sel    = 0;
      end else if (bank == BANK_1 && status[BANK1_GATE_BIT]) begin
        masked = pend & enable_mirror[1];
        base   = 32;
        sel    = 1;
      end else if (bank == BANK_2 && |status[BANK2_PEND_W-1:0]) begin
        masked = BANK_W'(status[BANK2_PEND_W-1:0]) & enable_mirror[2];
        base   = 64;
        sel    = 2;
      end
      masked = masked & handler_mirror[sel];
      // Highest set bit first; the lowest one closes the item.
      for (int i = BANK_W - 1; i >= 0; i--) begin
        if (masked[i]) begin
          due_results.push_back(make_result(SRC_W'(base + i), 1'b1, 1'b0,
                                            ~|(masked & ((BANK_W'(1) << i) - 1))));
          emitted++;
        end
      end
      if (emitted == 0) begin
        due_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
      end
    end else begin
      due_results.push_back(make_result('0, 1'b0, 1'b0, 1'b1));
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    irq_result_t want_r;
    if (!rst_n) begin
      for (int b = 0; b < NBANKS; b++) begin
        enable_mirror[b]  = '0;
        handler_mirror[b] = '0;
      end
      due_results.delete();
      mismatch_count = 0;
      result_count   = 0;
    end else begin
      // Results are compared before the new item is predicted, since a result
      // seen at this edge always belongs to an older item.
      if (out_valid) begin
        if (due_results.size() == 0) begin
          $error("unexpected result: source_out %0d fired %0b range_error %0b last %0b",
                 out_source_out, out_fired, out_range_error, out_last);
          mismatch_count++;
        end else begin
          want_r = due_results.pop_front();
          check_field("source_out", want_r.source, out_source_out);
          check_field("fired", want_r.fired, out_fired);
          check_field("range_error", want_r.range_error, out_range_error);
          check_field("last", want_r.last, out_last);
          result_count++;
        end
      end
      if (start && !busy) begin
        predict_item(in_mode, in_source_number, in_bank_select, in_basic_status,
                     in_pending_word);
      end
    end
    awaited_count <= due_results.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Top of the dispatcher testbench: clock, reset, item stimulus and the final verdict.
`timescale 1ns / 1ps

module testbench;
  import bidu_pkg::*;

  localparam int NUM_SOURCES  = 72;
  localparam int RANDOM_ITEMS = 150;
  // The limit is many times the length of the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;
  // Longer than the longest dispatch scan, so this covers any straggling result.
  localparam int DRAIN_CYCLES = 40;

  // Codes that the package leaves unnamed because the block treats them as unused.
  localparam logic [MODE_W-1:0] MODE_RSVD_5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSVD_7 = 3'd7;
  localparam logic [BSEL_W-1:0] BANK_UNUSED = 2'd3;

  localparam logic [STAT_W-1:0] GATE_BANK0  = STAT_W'(1) << BANK0_GATE_BIT;
  localparam logic [STAT_W-1:0] GATE_BANK1  = STAT_W'(1) << BANK1_GATE_BIT;
  localparam logic [STAT_W-1:0] STAT_ALL    = '1;
  localparam logic [STAT_W-1:0] STAT_NONE   = '0;
  localparam logic [BANK_W-1:0] PEND_ALL    = '1;
  localparam logic [BANK_W-1:0] PEND_NONE   = '0;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [MODE_W-1:0] in_mode = MODE_ENABLE;
  logic [SRC_W-1:0]  in_source_number = '0;
  logic [BSEL_W-1:0] in_bank_select = BANK_0;
  logic [STAT_W-1:0] in_basic_status = '0;
  logic [BANK_W-1:0] in_pending_word = '0;
  logic              out_valid;
  logic [SRC_W-1:0]  out_source_out;
  logic              out_fired;
  logic              out_range_error;
  logic              out_last;

  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned awaited_count;
  int unsigned cycle_count = 0;
  int unsigned items_sent = 0;
  int unsigned dispatches_sent = 0;
  // While this is non-zero, items follow one another without any gap.
  int unsigned gapless_left = 0;

  banked_interrupt_dispatcher_unit #(
    .NUM_SOURCES(NUM_SOURCES)
  ) i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_source_number(in_source_number),
    .in_bank_select  (in_bank_select),
    .in_basic_status (in_basic_status),
    .in_pending_word (in_pending_word),
    .out_valid       (out_valid),
    .out_source_out  (out_source_out),
    .out_fired       (out_fired),
    .out_range_error (out_range_error),
    .out_last        (out_last)
  );

  dispatch_checker #(
    .NUM_SOURCES(NUM_SOURCES)
  ) i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_source_number(in_source_number),
    .in_bank_select  (in_bank_select),
    .in_basic_status (in_basic_status),
    .in_pending_word (in_pending_word),
    .out_valid       (out_valid),
    .out_source_out  (out_source_out),
    .out_fired       (out_fired),
    .out_range_error (out_range_error),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .result_count    (result_count),
    .awaited_count   (awaited_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: a hung block or a result that never turns up ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Mostly back-to-back or short pauses, now and then a long one, so that
  // gaps land on every phase of a dispatch scan.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (gapless_left != 0) return 0;
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 8);
    return $urandom_range(15, 45);
  endfunction

  // Presents one item, holds it until the block takes it, then idles for a
  // random gap. It is always entered just after a rising edge, and start is
  // given one nonblocking assignment per edge at most.
  task automatic send_item(input logic [MODE_W-1:0] mode, input logic [SRC_W-1:0] src,
                           input logic [BSEL_W-1:0] bank, input logic [STAT_W-1:0] status,
                           input logic [BANK_W-1:0] pend);
    int unsigned gap;
    in_mode          <= mode;
    in_source_number <= src;
    in_bank_select   <= bank;
    in_basic_status  <= status;
    in_pending_word  <= pend;
    start            <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
    if (mode == MODE_DISPATCH) dispatches_sent++;
    if (gapless_left != 0) gapless_left--;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic [BANK_W-1:0] pick_pending();
    return ($urandom_range(0, 7) == 0) ? PEND_ALL : BANK_W'($urandom);
  endfunction

  // One random step of the traffic. Most steps are meaningful: arming a
  // source by enable then attach, or dispatching a bank whose gate is set.
  // The rest is disarming, noisy dispatches, bad source numbers and unused modes.
  task automatic random_step();
    int unsigned       pick;
    logic [SRC_W-1:0]  src;
    logic [BSEL_W-1:0] bank;
    logic [STAT_W-1:0] status;
    pick   = $urandom_range(0, 99);
    src    = SRC_W'($urandom_range(0, NUM_SOURCES - 1));
    bank   = BSEL_W'($urandom_range(BANK_0, BANK_2));
    status = STAT_W'($urandom);
    if (pick < 35) begin
      send_item(MODE_ENABLE, src, BSEL_W'($urandom), STAT_W'($urandom), BANK_W'($urandom));
      send_item(MODE_ATTACH, src, BSEL_W'($urandom), STAT_W'($urandom), BANK_W'($urandom));
    end else if (pick < 45) begin
      send_item(($urandom_range(0, 1) == 0) ? MODE_DISABLE : MODE_DETACH, src,
                BSEL_W'($urandom), STAT_W'($urandom), BANK_W'($urandom));
    end else if (pick < 75) begin
      // Force the gate of the chosen bank so that the scan really runs.
      case (bank)
        BANK_0:  status = status | GATE_BANK0;
        BANK_1:  status = status | GATE_BANK1;
        default: status = status | (STAT_W'(1) << $urandom_range(0, BANK2_PEND_W - 1));
      endcase
      send_item(MODE_DISPATCH, SRC_W'($urandom), bank, status, pick_pending());
    end else if (pick < 85) begin
      send_item(MODE_DISPATCH, SRC_W'($urandom), BSEL_W'($urandom), status, pick_pending());
    end else if (pick < 92) begin
      send_item(MODE_W'($urandom_range(MODE_ENABLE, MODE_DETACH)),
                SRC_W'($urandom_range(NUM_SOURCES, (1 << SRC_W) - 1)),
                BSEL_W'($urandom), status, BANK_W'($urandom));
    end else begin
      send_item(MODE_W'($urandom_range(MODE_RSVD_5, MODE_RSVD_7)), SRC_W'($urandom),
                BSEL_W'($urandom), status, BANK_W'($urandom));
    end
  endtask

  initial begin
    int unsigned directed_count;

    // Reset is asserted once, from the start, and released at a rising edge.
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A dispatch straight after reset finds nothing enabled.
    send_item(MODE_DISPATCH, '0, BANK_0, STAT_ALL, PEND_ALL);

    // Enable both ends of every bank, then attach handlers to some of them,
    // leaving sources 32 and 64 enabled but without a handler.
    send_item(MODE_ENABLE, SRC_W'(0), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ENABLE, SRC_W'(31), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ENABLE, SRC_W'(32), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ENABLE, SRC_W'(63), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ENABLE, SRC_W'(64), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ENABLE, SRC_W'(NUM_SOURCES - 1), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ATTACH, SRC_W'(0), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ATTACH, SRC_W'(31), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ATTACH, SRC_W'(63), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ATTACH, SRC_W'(NUM_SOURCES - 1), BANK_0, STAT_NONE, PEND_NONE);

    // Out-of-range sources: the first one beyond the end and the largest number.
    send_item(MODE_ENABLE, SRC_W'(NUM_SOURCES), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_ATTACH, '1, BANK_0, STAT_NONE, PEND_NONE);

    // Bank 0 with its gate set fires 31 then 0; with its gate clear it gives an empty result.
    send_item(MODE_DISPATCH, '0, BANK_0, GATE_BANK0, PEND_ALL);
    send_item(MODE_DISPATCH, '0, BANK_0, STAT_ALL & ~GATE_BANK0, PEND_ALL);
    // Bank 1 fires 63 only, as 32 has no handler.
    send_item(MODE_DISPATCH, '1, BANK_1, GATE_BANK1, PEND_ALL);
    // Bank 2 takes its pending bits from the low byte of the status word.
    send_item(MODE_DISPATCH, '0, BANK_2, STAT_W'(8'hFF), PEND_ALL);
    send_item(MODE_DISPATCH, '0, BANK_2, GATE_BANK0 | GATE_BANK1, PEND_ALL);
    // The unused bank and the unused modes each give one empty result.
    send_item(MODE_DISPATCH, '1, BANK_UNUSED, STAT_ALL, PEND_ALL);
    send_item(MODE_RSVD_5, '1, BANK_UNUSED, STAT_ALL, PEND_ALL);
    send_item(MODE_W'(MODE_RSVD_5 + 1), '1, BANK_UNUSED, STAT_ALL, PEND_ALL);
    send_item(MODE_RSVD_7, '1, BANK_UNUSED, STAT_ALL, PEND_ALL);

    // Disabling 0 and detaching 31 leaves bank 0 with nothing to dispatch.
    send_item(MODE_DISABLE, SRC_W'(0), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_DETACH, SRC_W'(31), BANK_0, STAT_NONE, PEND_NONE);
    send_item(MODE_DISPATCH, '0, BANK_0, STAT_ALL, PEND_ALL);
    directed_count = items_sent;

    // Random part, with the odd stretch of gapless items mixed in.
    while (items_sent < directed_count + RANDOM_ITEMS) begin
      if (gapless_left == 0 && $urandom_range(0, 15) == 0) gapless_left = 20;
      random_step();
    end
    start <= 1'b0;

    // The checker's count of awaited results is registered, so step once first.
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d items, %0d of them dispatches, in %0d cycles.",
             items_sent, dispatches_sent, cycle_count);
    $display("Checked %0d results against the predicted banks; %0d mismatches.",
             result_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bidu_pkg.sv
src/bidu_bank_store.sv
src/bidu_scan_unit.sv
src/banked_interrupt_dispatcher_unit.sv
dv/dispatch_checker.sv
dv/testbench.sv
